// ===== src/thermocouple_frame_moving_average_top_defines.svh =====
// Assertion macros shared by the thermocouple frame averager RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef THERMOCOUPLE_FRAME_MOVING_AVERAGE_TOP_DEFINES_SVH
`define THERMOCOUPLE_FRAME_MOVING_AVERAGE_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TFMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfma: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define TFMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfma: same-cycle check failed");

`endif

// ===== src/tfma_pkg.sv =====
// Package for the thermocouple frame averager: widths, command codes, word types.
// No dependencies.
`default_nettype none

package tfma_pkg;

   // Ring depth is a power of two; the average is a shift of the sum.
   localparam int SAMPLES_LOG2 = 3;
   localparam int SAMPLES      = 1 << SAMPLES_LOG2;
   localparam int SLOT_W       = SAMPLES_LOG2;

   localparam int FRAME_W      = 32;
   localparam int SAMPLE_W     = 12;
   localparam int TEMP_SHIFT   = 18;
   localparam int FAULT_W      = 3;
   localparam int SUM_W        = SAMPLE_W + SAMPLES_LOG2;
   localparam int SUM_EXT_W    = 18;
   localparam int OUT_SUM_W    = 15;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_PRIME  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              command;
      logic [FRAME_W-1:0]   raw_frame;
   } req_word_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample_quarters;
      logic [FAULT_W-1:0]   fault_bits;
      logic [SAMPLE_W-1:0]  average_quarters;
      logic [OUT_SUM_W-1:0] average_sum;
   } rsp_word_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sample;
      logic [FAULT_W-1:0]   faults;
   } decode_type;

endpackage

`default_nettype wire

// ===== src/tfma_decode.sv =====
// Frame field extraction: temperature count and fault flags.
// Depends on tfma_pkg.
`default_nettype none

module tfma_decode
   import tfma_pkg::*;
(
   input  wire logic [FRAME_W-1:0] raw_frame,
   output decode_type              decoded
);

   // Sign and upper bits are dropped; temperature sits just below them.
   assign decoded.sample = raw_frame[TEMP_SHIFT +: SAMPLE_W];
   assign decoded.faults = raw_frame[FAULT_W-1:0];

endmodule

`default_nettype wire

// ===== src/tfma_ring.sv =====
// Sample ring, write slot and running sum; gives the sum after the current word.
// Depends on tfma_pkg.
`default_nettype none

module tfma_ring
   import tfma_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire cmd_type             command,
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic [SUM_W-1:0]         sum_next
);

   logic [SAMPLE_W-1:0] ring_ff [SAMPLES];
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   slot_in;
   logic [SUM_W-1:0]    sum_ff;

   always_comb begin
      slot_in  = slot_ff;
      sum_next = sum_ff;
      case (command)
         CMD_PRIME: begin
            sum_next = SUM_W'(sample) << SAMPLES_LOG2;
         end
         default: begin
            // Drop the oldest entry, add the new one.
            sum_next = sum_ff - SUM_W'(ring_ff[slot_ff]) + SUM_W'(sample);
            slot_in  = SLOT_W'(slot_ff + 1'b1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         sum_ff  <= '0;
         for (int k = 0; k < SAMPLES; k++) begin
            ring_ff[k] <= '0;
         end
      end else if (fire) begin
         slot_ff <= slot_in;
         sum_ff  <= sum_next;
         for (int k = 0; k < SAMPLES; k++) begin
            if (command == CMD_PRIME || SLOT_W'(k) == slot_ff) begin
               ring_ff[k] <= sample;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/thermocouple_frame_moving_average_top.sv =====
// Thermocouple frame averager top level: input register, decode, ring, result register.
// Depends on tfma_pkg, tfma_decode, tfma_ring and the assertion macro header.
//
// Takes one 32-bit converter frame per word and returns one result word per
// frame: the decoded temperature (frame bits 29..18, quarter degrees), the fault
// flags (frame bits 2..0), the running sum of the last SAMPLES samples and the
// floor of its mean. An insert command replaces the oldest ring entry; a prime
// command fills the whole ring with the frame's sample, so the average equals
// that sample. The block sustains one word per cycle while the result is not
// stalled: a word is held in the input register, the ring and running sum
// update as it moves to the result register, and the next word is taken in
// the same cycle. Result valid rises once the word has moved from the input
// register into the result register. The running sum update (one subtract
// and one add of 15 bits) is the only path of note. Reset is synchronous and
// clears the ring, the write slot and the sum to zero.
`default_nettype none
`include "thermocouple_frame_moving_average_top_defines.svh"

module thermocouple_frame_moving_average_top
   import tfma_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_word_type  req_word,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_word_type       rsp_word
);

   logic             in_valid_ff;
   req_word_type     in_word_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;
   rsp_word_type     rsp_word_in;

   logic             out_free;
   logic             fire;
   logic             req_take;
   decode_type       decoded;
   logic [SUM_W-1:0] sum_next;
   logic [SUM_EXT_W-1:0] sum_wide;

   // Result register can take a word when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Move the held word into the result register and update the ring.
   assign fire      = in_valid_ff && out_free;
   // Hold the input register while its word cannot advance.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   tfma_decode u_decode (
      .raw_frame (in_word_ff.raw_frame),
      .decoded   (decoded)
   );

   tfma_ring u_ring (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .command  (in_word_ff.command),
      .sample   (decoded.sample),
      .sum_next (sum_next)
   );

   always_comb begin
      sum_wide                     = SUM_EXT_W'(sum_next);
      rsp_word_in.sample_quarters  = decoded.sample;
      rsp_word_in.fault_bits       = decoded.faults;
      // Mean is a shift: ring depth is a power of two.
      rsp_word_in.average_quarters = sum_next[SUM_W-1:SAMPLES_LOG2];
      rsp_word_in.average_sum      = sum_wide[OUT_SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= fire;
         end
      end
      // Payload registers: load on accept, hold otherwise.
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `TFMA_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, rsp_valid_ff)
   `TFMA_ASSERT_NEXT(a_prime_avg_is_sample, clock, reset,
                     fire && in_word_ff.command == CMD_PRIME,
                     rsp_word_ff.average_quarters == rsp_word_ff.sample_quarters)
   `TFMA_ASSERT_NEXT(a_stall_holds_input, clock, reset, req_stall,
                     in_valid_ff && $stable(in_word_ff))
   `TFMA_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall,
                     rsp_valid_ff && rsp_stall)

endmodule

`default_nettype wire
